// ----- design/lcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcbc_pkg
// shared constants and types for the local constraint box check
// ----------------------------------------------------------------------------
package lcbc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // register indexes
    localparam logic [1:0] REG_CURVE_OFFSET = 2'd0;
    localparam logic [1:0] REG_EQUAL_TOL    = 2'd1;
    localparam logic [1:0] REG_MONITOR_MODE = 2'd2;

    // reset values
    localparam logic signed [31:0] CURVE_OFFSET_RST = 32'sd131072;
    localparam logic [15:0]        EQUAL_TOL_RST    = 16'd7;
    localparam logic               MONITOR_MODE_RST = 1'b0;

    localparam logic MODE_VARIANCE = 1'b0;
    localparam logic MODE_AVERAGE  = 1'b1;

    // result reasons
    localparam logic [1:0] RSN_NONE     = 2'd0;
    localparam logic [1:0] RSN_TINY     = 2'd1;
    localparam logic [1:0] RSN_BOX      = 2'd2;
    localparam logic [1:0] RSN_STRADDLE = 2'd3;

    // square root pipeline: 33 result bits, two per stage
    localparam int SQ_STEPS     = 33;
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = (SQ_STEPS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

    // sideband that rides along with the square root
    typedef struct packed {
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic               use_var;
        logic               viol;
        logic [1:0]         reason;
    } side_t;

endpackage

// ----- design/lcbc_isqrt.sv -----
// ----------------------------------------------------------------------------
// lcbc_isqrt
// pipelined floor square root of a 65-bit value, two result bits per stage
// ----------------------------------------------------------------------------
module lcbc_isqrt
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [64:0]           in_val,
    input  lcbc_pkg::side_t       in_side,
    output logic                  out_vld,
    output logic [32:0]           out_root,
    output lcbc_pkg::side_t       out_side
);

    localparam int NST = lcbc_pkg::SQ_STAGES;
    localparam int PER = lcbc_pkg::SQ_PER_STAGE;

    logic [65:0]     val_reg  [NST];
    logic [35:0]     rem_reg  [NST];
    logic [32:0]     res_reg  [NST];
    lcbc_pkg::side_t side_reg [NST];
    logic [NST-1:0]  vld_reg;

    for (genvar j = 0; j < NST; j++) begin : g_stage
        logic [65:0]     val_prev;
        logic [35:0]     rem_prev;
        logic [32:0]     res_prev;
        lcbc_pkg::side_t side_prev;
        logic            vld_prev;
        logic [65:0]     val_next;
        logic [35:0]     rem_next;
        logic [32:0]     res_next;

        if (j == 0) begin : g_first
            assign val_prev  = {1'b0, in_val};
            assign rem_prev  = '0;
            assign res_prev  = '0;
            assign side_prev = in_side;
            assign vld_prev  = in_vld;
        end
        else begin : g_mid
            assign val_prev  = val_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign res_prev  = res_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign vld_prev  = vld_reg[j-1];
        end

        always_comb
        begin
            logic [35:0] trial;
            val_next = val_prev;
            rem_next = rem_prev;
            res_next = res_prev;
            for (int k = 0; k < PER; k++) begin
                if (j * PER + k < lcbc_pkg::SQ_STEPS) begin
                    rem_next = {rem_next[33:0], val_next[65:64]};
                    val_next = {val_next[63:0], 2'b00};
                    trial    = {1'b0, res_next, 2'b01};
                    if (rem_next >= trial) begin
                        rem_next = rem_next - trial;
                        res_next = {res_next[31:0], 1'b1};
                    end
                    else begin
                        res_next = {res_next[31:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end
            else begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[j]  <= val_next;
            rem_reg[j]  <= rem_next;
            res_reg[j]  <= res_next;
            side_reg[j] <= side_prev;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_root = res_reg[NST-1];
    assign out_side = side_reg[NST-1];

endmodule

// ----- design/local_constraint_box_check_top.sv -----
// ----------------------------------------------------------------------------
// local_constraint_box_check_top
// geometric monitoring local constraint check, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   an item (est_x, est_y, local_x, local_y) is taken at a clock edge with
//   start high and busy low; busy is always low, so one item per cycle
//   each item gives one result (violation, reason), shown for one cycle
//   with done high once the item has passed through every pipeline stage
//   throughput is one item per clock; the depth is set by the 33-step
//   square root, two root bits per stage, plus six stages around it:
//   differences, squares, sum, box edges, edge squares and the result
//   results come out in the order items went in; the receiver cannot
//   stall, so nothing is held back
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data,
//   cfg_ready always high; index 0 curve_offset, 1 equal_tolerance,
//   2 monitor_mode, other indexes are ignored; write only while idle
//   reset clears all valid bits in flight and loads the register defaults
// ----------------------------------------------------------------------------
module local_constraint_box_check_top
#(
    parameter int FRAC_BITS = lcbc_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] est_x,
    input  logic signed [31:0] est_y,
    input  logic signed [31:0] local_x,
    input  logic signed [31:0] local_y,
    // result channel
    output logic               done,
    output logic               violation,
    output logic [1:0]         reason,
    // configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int KW  = 37 + FRAC_BITS;   // width of scaled curve bound
    localparam int LAT = 6 + lcbc_pkg::SQ_STAGES;

    // ---------------- configuration registers ----------------
    logic signed [31:0] curve_offset_reg;
    logic [15:0]        equal_tol_reg;
    logic               mode_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            curve_offset_reg <= lcbc_pkg::CURVE_OFFSET_RST;
            equal_tol_reg    <= lcbc_pkg::EQUAL_TOL_RST;
            mode_reg         <= lcbc_pkg::MONITOR_MODE_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcbc_pkg::REG_CURVE_OFFSET: curve_offset_reg <= cfg_data;
                lcbc_pkg::REG_EQUAL_TOL:    equal_tol_reg    <= cfg_data[15:0];
                lcbc_pkg::REG_MONITOR_MODE: mode_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: differences, sums, early decisions ----------------
    logic signed [32:0] dx, dy;
    logic [31:0]        mx, my;
    logic               eqx, eqy, straddle;
    logic               s1_vld_reg;
    logic [31:0]        s1_mx_reg, s1_my_reg;
    lcbc_pkg::side_t    s1_side_reg, s1_side_next;

    always_comb
    begin
        dx = 33'(est_x) - 33'(local_x);
        dy = 33'(est_y) - 33'(local_y);
        mx = dx[32] ? 32'(-dx) : dx[31:0];
        my = dy[32] ? 32'(-dy) : dy[31:0];
        eqx = (mx == 32'd0) || (mx < {16'd0, equal_tol_reg});
        eqy = (my == 32'd0) || (my < {16'd0, equal_tol_reg});
        // either x on the threshold counts as a straddle
        straddle = ((est_x >= curve_offset_reg) && (local_x <= curve_offset_reg))
                || ((est_x <= curve_offset_reg) && (local_x >= curve_offset_reg));
        s1_side_next.cx      = 33'(est_x) + 33'(local_x);
        s1_side_next.cy      = 33'(est_y) + 33'(local_y);
        s1_side_next.use_var = 1'b0;
        s1_side_next.viol    = 1'b0;
        s1_side_next.reason  = lcbc_pkg::RSN_NONE;
        if (eqx && eqy) begin
            s1_side_next.reason = lcbc_pkg::RSN_TINY;
        end
        else if (mode_reg == lcbc_pkg::MODE_AVERAGE) begin
            if (straddle) begin
                s1_side_next.viol   = 1'b1;
                s1_side_next.reason = lcbc_pkg::RSN_STRADDLE;
            end
        end
        else begin
            s1_side_next.use_var = 1'b1;
        end
    end

    // ---------------- stage 2: squares of the differences ----------------
    logic               s2_vld_reg;
    logic [63:0]        s2_sx_reg, s2_sy_reg;
    lcbc_pkg::side_t    s2_side_reg;

    // ---------------- stage 3: squared diameter, 65 bits ----------------
    logic               s3_vld_reg;
    logic [64:0]        s3_sum_reg;
    lcbc_pkg::side_t    s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mx_reg   <= mx;
        s1_my_reg   <= my;
        s1_side_reg <= s1_side_next;
        s2_sx_reg   <= s1_mx_reg * s1_mx_reg;
        s2_sy_reg   <= s1_my_reg * s1_my_reg;
        s2_side_reg <= s1_side_reg;
        s3_sum_reg  <= {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};
        s3_side_reg <= s2_side_reg;
    end

    // ---------------- radius: pipelined square root ----------------
    logic            sq_vld;
    logic [32:0]     sq_root;
    lcbc_pkg::side_t sq_side;

    lcbc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .in_val   (s3_sum_reg),
        .in_side  (s3_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ---------------- stage A: box edges and scaled curve bounds ----------------
    logic signed [34:0]   lft, rgt, up, dn;
    logic signed [35:0]   up_t, dn_t;
    logic [34:0]          lm, rm;
    logic                 sa_vld_reg;
    logic signed [34:0]   sa_lft_reg, sa_rgt_reg;
    logic [31:0]          sa_lm_reg, sa_rm_reg;
    logic                 sa_lbig_reg, sa_rbig_reg;
    logic signed [KW-1:0] sa_ku_reg, sa_kd_reg;
    lcbc_pkg::side_t      sa_side_reg;

    always_comb
    begin
        lft  = 35'(sq_side.cx) - 35'(sq_root);
        rgt  = 35'(sq_side.cx) + 35'(sq_root);
        up   = 35'(sq_side.cy) + 35'(sq_root);
        dn   = 35'(sq_side.cy) - 35'(sq_root);
        up_t = 36'(up) - (36'(curve_offset_reg) <<< 1);
        dn_t = 36'(dn) - (36'(curve_offset_reg) <<< 1);
        lm   = lft[34] ? 35'(-lft) : lft;
        rm   = rgt[34] ? 35'(-rgt) : rgt;
    end

    // ---------------- stage B: squares of the vertical edges ----------------
    logic                 sb_vld_reg;
    logic signed [34:0]   sb_lft_reg, sb_rgt_reg;
    logic [63:0]          sb_lsq_reg, sb_rsq_reg;
    logic                 sb_lbig_reg, sb_rbig_reg;
    logic signed [KW-1:0] sb_ku_reg, sb_kd_reg;
    lcbc_pkg::side_t      sb_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
        end
        else begin
            sa_vld_reg <= sq_vld;
            sb_vld_reg <= sa_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_lft_reg  <= lft;
        sa_rgt_reg  <= rgt;
        sa_lm_reg   <= lm[31:0];
        sa_rm_reg   <= rm[31:0];
        sa_lbig_reg <= |lm[34:32];
        sa_rbig_reg <= |rm[34:32];
        sa_ku_reg   <= KW'(up_t) <<< (FRAC_BITS + 1);
        sa_kd_reg   <= KW'(dn_t) <<< (FRAC_BITS + 1);
        sa_side_reg <= sq_side;
        sb_lft_reg  <= sa_lft_reg;
        sb_rgt_reg  <= sa_rgt_reg;
        sb_lsq_reg  <= sa_lm_reg * sa_lm_reg;
        sb_rsq_reg  <= sa_rm_reg * sa_rm_reg;
        sb_lbig_reg <= sa_lbig_reg;
        sb_rbig_reg <= sa_rbig_reg;
        sb_ku_reg   <= sa_ku_reg;
        sb_kd_reg   <= sa_kd_reg;
        sb_side_reg <= sa_side_reg;
    end

    // ---------------- stage C: exact edge crossing tests ----------------
    // x*x against k: greater when |x| is too big or k negative
    logic [63:0] ku_u, kd_u;
    logic        ku_neg, kd_neg, ku_pos, kd_pos;
    logic        l_gt_u, l_lt_u, l_gt_d, l_lt_d;
    logic        r_gt_u, r_lt_u, r_gt_d, r_lt_d;
    logic        l_neg, r_pos, flag;
    logic        done_reg, violation_reg;
    logic [1:0]  reason_reg;
    logic        violation_next;
    logic [1:0]  reason_next;

    always_comb
    begin
        ku_neg = sb_ku_reg[KW-1];
        kd_neg = sb_kd_reg[KW-1];
        ku_pos = !ku_neg && (sb_ku_reg != '0);
        kd_pos = !kd_neg && (sb_kd_reg != '0);
        ku_u   = 64'(unsigned'(sb_ku_reg));
        kd_u   = 64'(unsigned'(sb_kd_reg));
        l_gt_u = sb_lbig_reg || ku_neg || (sb_lsq_reg > ku_u);
        l_lt_u = !sb_lbig_reg && !ku_neg && (sb_lsq_reg < ku_u);
        l_gt_d = sb_lbig_reg || kd_neg || (sb_lsq_reg > kd_u);
        l_lt_d = !sb_lbig_reg && !kd_neg && (sb_lsq_reg < kd_u);
        r_gt_u = sb_rbig_reg || ku_neg || (sb_rsq_reg > ku_u);
        r_lt_u = !sb_rbig_reg && !ku_neg && (sb_rsq_reg < ku_u);
        r_gt_d = sb_rbig_reg || kd_neg || (sb_rsq_reg > kd_u);
        r_lt_d = !sb_rbig_reg && !kd_neg && (sb_rsq_reg < kd_u);
        l_neg  = sb_lft_reg[34];
        r_pos  = !sb_rgt_reg[34] && (sb_rgt_reg != '0);

        // vertical edges strictly between bottom and top
        flag = (l_lt_u && l_gt_d) || (r_lt_u && r_gt_d);
        // bottom edge
        if (kd_pos) begin
            if ((l_neg || l_lt_d) && (r_pos && r_gt_d)) flag = 1'b1;
            if ((l_neg && l_gt_d) && (r_pos || r_lt_d)) flag = 1'b1;
        end
        // top edge
        if (ku_pos) begin
            if ((l_neg || l_lt_u) && (r_pos && r_gt_u)) flag = 1'b1;
            if ((l_neg && l_gt_u) && (r_pos || r_lt_u)) flag = 1'b1;
        end

        violation_next = sb_side_reg.viol;
        reason_next    = sb_side_reg.reason;
        if (sb_side_reg.use_var) begin
            violation_next = flag;
            reason_next    = flag ? lcbc_pkg::RSN_BOX : lcbc_pkg::RSN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= sb_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        violation_reg <= violation_next;
        reason_reg    <= reason_next;
    end

    assign done      = done_reg;
    assign violation = violation_reg;
    assign reason    = reason_reg;

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item did not give a result after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching item");

    a_viol_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (done && violation) |->
            (reason == lcbc_pkg::RSN_BOX || reason == lcbc_pkg::RSN_STRADDLE))
        else $error("violation with a non-violation reason");

    a_quiet_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !violation) |->
            (reason == lcbc_pkg::RSN_NONE || reason == lcbc_pkg::RSN_TINY))
        else $error("no violation but a violation reason");

endmodule
